FILE: hw/rtl/ssp_pkg.sv
// Package for the seek/flee/pursue/evade steering block.
// Field widths, operation codes and the payload structs; no dependencies.
package ssp_pkg;

  localparam int unsigned DATA_W        = 24;
  localparam int unsigned SPEED_W       = 23;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // difference of two positions, its magnitude and square
  localparam int unsigned DIFF_W = DATA_W + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned L2_W   = SQ_W + 1;
  localparam int unsigned ROOT_W = (L2_W + 1) / 2;
  // aim vector after prediction and optional reversal
  localparam int unsigned AIM_W  = DATA_W + 2;
  localparam int unsigned MAG_W  = AIM_W - 1;
  localparam int unsigned PROD_W = MAG_W + SPEED_W;
  localparam int unsigned NUM_W  = PROD_W + 1;
  localparam int unsigned QS_W   = DATA_W;

  typedef enum logic [1:0] {
    OP_SEEK   = 2'd0,
    OP_FLEE   = 2'd1,
    OP_PURSUE = 2'd2,
    OP_EVADE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic        [SPEED_W-1:0] top;
    logic signed [DATA_W-1:0] gx;
    logic signed [DATA_W-1:0] gy;
    logic signed [DATA_W-1:0] gvx;
    logic signed [DATA_W-1:0] gvy;
  } item_t;

  typedef struct packed {
    item_t it;
    logic  big;
  } lead_side_t;

  typedef struct packed {
    logic signed [AIM_W-1:0]  ax;
    logic signed [AIM_W-1:0]  ay;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic        [SPEED_W-1:0] top;
    logic                     tiny;
  } aim_side_t;

endpackage

FILE: hw/rtl/ssp_item_if.sv
// Channel interfaces: agent item in, steering force out.
// Depends on ssp_pkg.
interface ssp_item_if import ssp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_t                       operation;
  logic signed [DATA_W-1:0]  agent_pos_x;
  logic signed [DATA_W-1:0]  agent_pos_y;
  logic signed [DATA_W-1:0]  agent_vel_x;
  logic signed [DATA_W-1:0]  agent_vel_y;
  logic        [SPEED_W-1:0] top_speed;
  logic signed [DATA_W-1:0]  goal_x;
  logic signed [DATA_W-1:0]  goal_y;
  logic signed [DATA_W-1:0]  goal_vel_x;
  logic signed [DATA_W-1:0]  goal_vel_y;

  modport source (output valid, operation, agent_pos_x, agent_pos_y, agent_vel_x,
                  agent_vel_y, top_speed, goal_x, goal_y, goal_vel_x, goal_vel_y,
                  input ready);
  modport sink   (input valid, operation, agent_pos_x, agent_pos_y, agent_vel_x,
                  agent_vel_y, top_speed, goal_x, goal_y, goal_vel_x, goal_vel_y,
                  output ready);
endinterface

interface ssp_force_if import ssp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] force_x;
  logic signed [DATA_W-1:0] force_y;

  modport source (output valid, force_x, force_y, input ready);
  modport sink   (input valid, force_x, force_y, output ready);
endinterface

FILE: hw/rtl/ssp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Self-contained; a sideband vector travels alongside each beat.
module ssp_isqrt #(
  parameter int unsigned ROOT_W = 26,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     out_side
);

  logic                vld  [ROOT_W];
  logic [ROOT_W+1:0]   rem  [ROOT_W];
  logic [ROOT_W-1:0]   res  [ROOT_W];
  logic [2*ROOT_W-1:0] rad  [ROOT_W];
  logic [SIDE_W-1:0]   side [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic                vld_in;
    logic [ROOT_W+1:0]   rem_in;
    logic [ROOT_W-1:0]   res_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [SIDE_W-1:0]   side_in;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign res_in  = '0;
      assign rad_in  = radicand;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[g-1];
      assign rem_in  = rem[g-1];
      assign res_in  = res[g-1];
      assign rad_in  = rad[g-1];
      assign side_in = side[g-1];
    end

    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
    assign trial  = {res_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_in;
      end
      if (en) begin
        if (rem_sh >= trial) begin
          rem[g] <= rem_sh - trial;
          res[g] <= {res_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem[g] <= rem_sh;
          res[g] <= {res_in[ROOT_W-2:0], 1'b0};
        end
        rad[g]  <= rad_in << 2;
        side[g] <= side_in;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = res[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

FILE: hw/rtl/ssp_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Needs rem0 < den on entry; self-contained, sideband travels with each beat.
module ssp_divider #(
  parameter int unsigned DEN_W  = 26,
  parameter int unsigned Q_W    = 24,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem0,
  input  logic [Q_W-1:0]    low,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [Q_W];
  logic [DEN_W-1:0]  rem  [Q_W];
  logic [Q_W-1:0]    lo   [Q_W];
  logic [Q_W-1:0]    q    [Q_W];
  logic [DEN_W-1:0]  dv   [Q_W];
  logic [SIDE_W-1:0] side [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [Q_W-1:0]    lo_in;
    logic [Q_W-1:0]    q_in;
    logic [DEN_W-1:0]  dv_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    sh;
    logic [DEN_W:0]    diff;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = rem0;
      assign lo_in   = low;
      assign q_in    = '0;
      assign dv_in   = den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[g-1];
      assign rem_in  = rem[g-1];
      assign lo_in   = lo[g-1];
      assign q_in    = q[g-1];
      assign dv_in   = dv[g-1];
      assign side_in = side[g-1];
    end

    assign sh   = {rem_in, lo_in[Q_W-1]};
    assign diff = sh - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_in;
      end
      if (en) begin
        if (sh >= {1'b0, dv_in}) begin
          rem[g] <= diff[DEN_W-1:0];
          q[g]   <= {q_in[Q_W-2:0], 1'b1};
        end else begin
          rem[g] <= sh[DEN_W-1:0];
          q[g]   <= {q_in[Q_W-2:0], 1'b0};
        end
        lo[g]   <= lo_in << 1;
        dv[g]   <= dv_in;
        side[g] <= side_in;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot      = q[Q_W-1];
  assign out_side  = side[Q_W-1];

endmodule

FILE: hw/rtl/steering_seek_pursue_force_top.sv
// Steering force top level: distance, lead time, prediction, rescale, saturate.
// Depends on ssp_pkg, ssp_item_if / ssp_force_if, ssp_isqrt and ssp_divider.
//
//   channel  dir  beat contents
//   item     in   operation, agent pos/vel, top_speed, goal pos/vel
//   result   out  force_x, force_y
//
// Fixed pipeline: one beat in per cycle unless stalled; 12 register stages plus
// two 26-stage square roots, FRAC_BITS lead-time divide stages and a 24-stage
// rescale divide. The whole pipe advances together when the output register
// is empty or being taken, so a stall holds every stage in place.
// Synchronous reset clears only valid bits; no start-up sweep.
module steering_seek_pursue_force_top import ssp_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ssp_item_if.sink    item,
  ssp_force_if.source result
);

  localparam int unsigned LEAD_MAX = (6 * (1 << FRAC_BITS)) / 10;
  localparam longint unsigned TINY_L2 =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;
  localparam logic [SPEED_W-1:0] ONE_Q = SPEED_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] LEAD_Q = FRAC_BITS'(LEAD_MAX);

  logic en;
  logic out_v;

  assign en         = !out_v || result.ready;
  assign item.ready = en;

  // stage 1: capture, goal minus agent
  item_t                    s1_it, in_it;
  logic                     s1_v;
  logic signed [DIFF_W-1:0] s1_dx, s1_dy;

  assign in_it = '{op: item.operation, px: item.agent_pos_x, py: item.agent_pos_y,
                   vx: item.agent_vel_x, vy: item.agent_vel_y, top: item.top_speed,
                   gx: item.goal_x, gy: item.goal_y, gvx: item.goal_vel_x,
                   gvy: item.goal_vel_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= item.valid;
    end
    if (en) begin
      s1_it <= in_it;
      s1_dx <= DIFF_W'(item.goal_x) - DIFF_W'(item.agent_pos_x);
      s1_dy <= DIFF_W'(item.goal_y) - DIFF_W'(item.agent_pos_y);
    end
  end

  // stage 2: squares
  item_t             s2_it;
  logic              s2_v;
  logic [SQ_W-1:0]   s2_sqx, s2_sqy;
  logic [DIFF_W-1:0] m1x, m1y;

  assign m1x = s1_dx[DIFF_W-1] ? DIFF_W'(-s1_dx) : DIFF_W'(s1_dx);
  assign m1y = s1_dy[DIFF_W-1] ? DIFF_W'(-s1_dy) : DIFF_W'(s1_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_it  <= s1_it;
      s2_sqx <= m1x * m1x;
      s2_sqy <= m1y * m1y;
    end
  end

  // stage 3: squared distance
  item_t           s3_it;
  logic            s3_v;
  logic [L2_W-1:0] s3_l2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_it <= s2_it;
      s3_l2 <= L2_W'(s2_sqx) + L2_W'(s2_sqy);
    end
  end

  logic              r1_v;
  logic [ROOT_W-1:0] r1_root;
  item_t             r1_it;

  ssp_isqrt #(.ROOT_W(ROOT_W), .SIDE_W($bits(item_t))) u_dist (
    .clk, .rst, .en,
    .in_valid (s3_v),
    .radicand ({{(2*ROOT_W-L2_W){1'b0}}, s3_l2}),
    .in_side  (s3_it),
    .out_valid(r1_v),
    .root     (r1_root),
    .out_side (r1_it)
  );

  // stage 4: lead-time divide set-up
  lead_side_t         s4_side;
  logic               s4_v;
  logic [SPEED_W-1:0] s4_rem0, s4_den;
  logic [SPEED_W-1:0] den4;
  logic               big4;

  assign den4 = (r1_it.top < ONE_Q) ? ONE_Q : r1_it.top;
  assign big4 = r1_root >= ROOT_W'(den4);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= r1_v;
    end
    if (en) begin
      s4_side <= '{it: r1_it, big: big4};
      s4_den  <= den4;
      s4_rem0 <= big4 ? '0 : r1_root[SPEED_W-1:0];
    end
  end

  logic                 ld_v;
  logic [FRAC_BITS-1:0] ld_q;
  lead_side_t           ld_side;

  ssp_divider #(.DEN_W(SPEED_W), .Q_W(FRAC_BITS), .SIDE_W($bits(lead_side_t))) u_lead (
    .clk, .rst, .en,
    .in_valid (s4_v),
    .rem0     (s4_rem0),
    .low      ('0),
    .den      (s4_den),
    .in_side  (s4_side),
    .out_valid(ld_v),
    .quot     (ld_q),
    .out_side (ld_side)
  );

  // stage 5: clamp lead time
  item_t                s5_it;
  logic                 s5_v;
  logic [FRAC_BITS-1:0] s5_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= ld_v;
    end
    if (en) begin
      s5_it <= ld_side.it;
      s5_t  <= (ld_side.big || ld_q > LEAD_Q) ? LEAD_Q : ld_q;
    end
  end

  // stage 6: goal velocity times lead time
  item_t                          s6_it;
  logic                           s6_v;
  logic signed [DATA_W+FRAC_BITS:0] s6_ox, s6_oy;
  logic signed [FRAC_BITS:0]      t5s;

  assign t5s = $signed({1'b0, s5_t});

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
    if (en) begin
      s6_it <= s5_it;
      s6_ox <= s5_it.gvx * t5s;
      s6_oy <= s5_it.gvy * t5s;
    end
  end

  // stage 7: predicted goal and aim vector
  logic                     s7_v;
  logic signed [AIM_W-1:0]  s7_ax, s7_ay;
  logic signed [DATA_W-1:0] s7_vx, s7_vy;
  logic [SPEED_W-1:0]       s7_top;
  logic signed [DATA_W+FRAC_BITS:0] shx, shy;
  logic signed [AIM_W-1:0]  pgx, pgy, ax7, ay7;
  logic                     predict, away;

  assign predict = (s6_it.op == OP_PURSUE) || (s6_it.op == OP_EVADE);
  assign away    = (s6_it.op == OP_FLEE) || (s6_it.op == OP_EVADE);
  assign shx     = s6_ox >>> FRAC_BITS;
  assign shy     = s6_oy >>> FRAC_BITS;
  assign pgx     = predict ? AIM_W'(s6_it.gx) + AIM_W'(shx) : AIM_W'(s6_it.gx);
  assign pgy     = predict ? AIM_W'(s6_it.gy) + AIM_W'(shy) : AIM_W'(s6_it.gy);
  assign ax7     = away ? AIM_W'(s6_it.px) - pgx : pgx - AIM_W'(s6_it.px);
  assign ay7     = away ? AIM_W'(s6_it.py) - pgy : pgy - AIM_W'(s6_it.py);

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
    if (en) begin
      s7_ax  <= ax7;
      s7_ay  <= ay7;
      s7_vx  <= s6_it.vx;
      s7_vy  <= s6_it.vy;
      s7_top <= s6_it.top;
    end
  end

  // stage 8: aim squares
  logic                     s8_v;
  logic signed [AIM_W-1:0]  s8_ax, s8_ay;
  logic signed [DATA_W-1:0] s8_vx, s8_vy;
  logic [SPEED_W-1:0]       s8_top;
  logic [SQ_W-1:0]          s8_sqx, s8_sqy;
  logic [MAG_W-1:0]         m7x, m7y;

  assign m7x = s7_ax[AIM_W-1] ? MAG_W'(-s7_ax) : MAG_W'(s7_ax);
  assign m7y = s7_ay[AIM_W-1] ? MAG_W'(-s7_ay) : MAG_W'(s7_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
    if (en) begin
      s8_ax  <= s7_ax;
      s8_ay  <= s7_ay;
      s8_vx  <= s7_vx;
      s8_vy  <= s7_vy;
      s8_top <= s7_top;
      s8_sqx <= m7x * m7x;
      s8_sqy <= m7y * m7y;
    end
  end

  // stage 9: squared length, tiny-vector flag
  logic            s9_v;
  aim_side_t       s9_side;
  logic [L2_W-1:0] s9_l2, l2_8;

  assign l2_8 = L2_W'(s8_sqx) + L2_W'(s8_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
    if (en) begin
      s9_l2   <= l2_8;
      s9_side <= '{ax: s8_ax, ay: s8_ay, vx: s8_vx, vy: s8_vy, top: s8_top,
                   tiny: (l2_8 < L2_W'(TINY_L2)) || (l2_8 == '0)};
    end
  end

  logic              r2_v;
  logic [ROOT_W-1:0] r2_len;
  aim_side_t         r2_side;

  ssp_isqrt #(.ROOT_W(ROOT_W), .SIDE_W($bits(aim_side_t))) u_len (
    .clk, .rst, .en,
    .in_valid (s9_v),
    .radicand ({{(2*ROOT_W-L2_W){1'b0}}, s9_l2}),
    .in_side  (s9_side),
    .out_valid(r2_v),
    .root     (r2_len),
    .out_side (r2_side)
  );

  // stage 10: |aim| times top speed
  logic              s10_v;
  aim_side_t         s10_side;
  logic [ROOT_W-1:0] s10_len;
  logic [PROD_W-1:0] s10_px, s10_py;
  logic [MAG_W-1:0]  m9x, m9y;

  assign m9x = r2_side.ax[AIM_W-1] ? MAG_W'(-r2_side.ax) : MAG_W'(r2_side.ax);
  assign m9y = r2_side.ay[AIM_W-1] ? MAG_W'(-r2_side.ay) : MAG_W'(r2_side.ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= r2_v;
    end
    if (en) begin
      s10_side <= r2_side;
      s10_len  <= r2_len;
      s10_px   <= m9x * r2_side.top;
      s10_py   <= m9y * r2_side.top;
    end
  end

  // stage 11: rounding bias, divide set-up
  logic              s11_v;
  aim_side_t         s11_side;
  logic [NUM_W-1:0]  s11_nx, s11_ny;
  logic [ROOT_W-1:0] s11_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (en) begin
      s11_v <= s10_v;
    end
    if (en) begin
      s11_side <= s10_side;
      s11_nx   <= NUM_W'(s10_px) + NUM_W'(s10_len >> 1);
      s11_ny   <= NUM_W'(s10_py) + NUM_W'(s10_len >> 1);
      s11_den  <= s10_side.tiny ? ROOT_W'(1) : s10_len;
    end
  end

  logic            dx_v, dy_v, dy_neg;
  logic [QS_W-1:0] qx, qy;
  aim_side_t       dx_side;

  ssp_divider #(.DEN_W(ROOT_W), .Q_W(QS_W), .SIDE_W($bits(aim_side_t))) u_scale_x (
    .clk, .rst, .en,
    .in_valid (s11_v),
    .rem0     (ROOT_W'(s11_nx[NUM_W-1:QS_W])),
    .low      (s11_nx[QS_W-1:0]),
    .den      (s11_den),
    .in_side  (s11_side),
    .out_valid(dx_v),
    .quot     (qx),
    .out_side (dx_side)
  );

  ssp_divider #(.DEN_W(ROOT_W), .Q_W(QS_W), .SIDE_W(1)) u_scale_y (
    .clk, .rst, .en,
    .in_valid (s11_v),
    .rem0     (ROOT_W'(s11_ny[NUM_W-1:QS_W])),
    .low      (s11_ny[QS_W-1:0]),
    .den      (s11_den),
    .in_side  (s11_side.ay[AIM_W-1]),
    .out_valid(dy_v),
    .quot     (qy),
    .out_side (dy_neg)
  );

  // output register: subtract velocity, saturate
  logic signed [AIM_W-1:0]  sx, sy, aimx, aimy;
  logic signed [AIM_W:0]    fx, fy;
  logic signed [DATA_W-1:0] force_x, force_y;
  logic signed [DATA_W-1:0] satx, saty;

  localparam logic signed [AIM_W:0] F_MAX = (AIM_W+1)'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [AIM_W:0] F_MIN = -(AIM_W+1)'(2 ** (DATA_W - 1));

  assign sx   = dx_side.ax[AIM_W-1] ? -AIM_W'(qx) : AIM_W'(qx);
  assign sy   = dy_neg ? -AIM_W'(qy) : AIM_W'(qy);
  assign aimx = dx_side.tiny ? dx_side.ax : sx;
  assign aimy = dx_side.tiny ? dx_side.ay : sy;
  assign fx   = (AIM_W+1)'(aimx) - (AIM_W+1)'(dx_side.vx);
  assign fy   = (AIM_W+1)'(aimy) - (AIM_W+1)'(dx_side.vy);

  always_comb begin
    if (fx > F_MAX) begin
      satx = DATA_W'(F_MAX);
    end else if (fx < F_MIN) begin
      satx = DATA_W'(F_MIN);
    end else begin
      satx = DATA_W'(fx);
    end
    if (fy > F_MAX) begin
      saty = DATA_W'(F_MAX);
    end else if (fy < F_MIN) begin
      saty = DATA_W'(F_MIN);
    end else begin
      saty = DATA_W'(fy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dx_v && dy_v;
    end
    if (en) begin
      force_x <= satx;
      force_y <= saty;
    end
  end

  assign result.valid   = out_v;
  assign result.force_x = force_x;
  assign result.force_y = force_y;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the seek/flee/pursue/evade steering block.
// Depends on ssp_pkg, ssp_item_if, ssp_force_if and steering_seek_pursue_force_top.
// Random bursty stimulus, stalling receiver, in-order compare against a local predictor.
`timescale 1ns / 1ps

module tb;
  import ssp_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] fx;
    logic signed [DATA_W-1:0] fy;
  } force_t;

  localparam int LATENCY = 12 + 52 + FRAC_BITS_DEF + 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssp_item_if  item ();
  ssp_force_if result ();

  steering_seek_pursue_force_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t  agents[$];
  force_t forces_due[$];
  int     errors = 0;
  int     accepted = 0;
  int     gap_left = 0;
  int     burst_left = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rescale(longint a, longint top, longint len);
    longint q;
    q = (absv(a) * top + len / 2) / len;
    return a < 0 ? -q : q;
  endfunction

  function automatic logic [DATA_W-1:0] clip(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[DATA_W-1:0];
  endfunction

  function automatic force_t steer(item_t it);
    longint px, py, vx, vy, gx, gy, gvx, gvy, top, ax, ay, span, den, t, l2, len;
    force_t f;
    px = it.px; py = it.py; vx = it.vx; vy = it.vy;
    gx = it.gx; gy = it.gy; gvx = it.gvx; gvy = it.gvy;
    top = longint'(it.top);
    if (it.op == OP_PURSUE || it.op == OP_EVADE) begin
      span = int_root((gx - px) * (gx - px) + (gy - py) * (gy - py));
      den = top < (1 << FRAC_BITS_DEF) ? (1 << FRAC_BITS_DEF) : top;
      t = (span << FRAC_BITS_DEF) / den;
      if (t > (6 * (1 << FRAC_BITS_DEF)) / 10) t = (6 * (1 << FRAC_BITS_DEF)) / 10;
      gx = gx + ((gvx * t) >>> FRAC_BITS_DEF);
      gy = gy + ((gvy * t) >>> FRAC_BITS_DEF);
    end
    if (it.op == OP_SEEK || it.op == OP_PURSUE) begin
      ax = gx - px; ay = gy - py;
    end else begin
      ax = px - gx; ay = py - gy;
    end
    l2 = ax * ax + ay * ay;
    if (l2 != 0) begin
      len = int_root(l2);
      ax = rescale(ax, top, len);
      ay = rescale(ay, top, len);
    end
    f.fx = clip(ax - vx);
    f.fy = clip(ay - vy);
    return f;
  endfunction

  function automatic logic [DATA_W-1:0] coord(bit wide);
    int s;
    if (wide) return DATA_W'($urandom());
    s = $urandom_range(0, 8191);
    return DATA_W'(s - 4096);
  endfunction

  function automatic item_t random_agent();
    item_t it;
    bit wide;
    wide = ($urandom_range(0, 9) < 3);
    it.op  = op_t'($urandom_range(0, 3));
    it.px  = coord(wide);
    it.py  = coord(wide);
    it.vx  = coord(wide);
    it.vy  = coord(wide);
    it.top = wide ? SPEED_W'($urandom()) : SPEED_W'($urandom_range(0, 3000));
    it.gx  = coord(wide);
    it.gy  = coord(wide);
    it.gvx = coord(wide);
    it.gvy = coord(wide);
    if ($urandom_range(0, 19) == 0) begin
      it.gx = it.px;
      it.gy = it.py;
    end
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        forces_due.push_back(steer(agents[0]));
        agents.pop_front();
        accepted <= accepted + 1;
      end
      if (!(item.valid && !item.ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item.valid <= 1'b0;
        end else if (agents.size() == 0) begin
          item.valid <= 1'b0;
        end else begin
          item.valid       <= 1'b1;
          item.operation   <= agents[0].op;
          item.agent_pos_x <= agents[0].px;
          item.agent_pos_y <= agents[0].py;
          item.agent_vel_x <= agents[0].vx;
          item.agent_vel_y <= agents[0].vy;
          item.top_speed   <= agents[0].top;
          item.goal_x      <= agents[0].gx;
          item.goal_y      <= agents[0].gy;
          item.goal_vel_x  <= agents[0].gvx;
          item.goal_vel_y  <= agents[0].gvy;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result.ready <= 1'b0;
    end else if (!hold_done && accepted > 400) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ((accepted / 128) % 2 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    force_t want;
    if (!rst && result.valid && result.ready) begin
      if (forces_due.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected beat: %h %h", result.force_x, result.force_y);
      end else begin
        want = forces_due.pop_front();
        if (want.fx !== result.force_x || want.fy !== result.force_y) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: expected %h %h, got %h %h",
                     want.fx, want.fy, result.force_x, result.force_y);
        end
      end
    end
  end

  initial begin
    item_t it;
    item.operation   = OP_SEEK;
    item.agent_pos_x = '0; item.agent_pos_y = '0;
    item.agent_vel_x = '0; item.agent_vel_y = '0;
    item.top_speed   = '0;
    item.goal_x      = '0; item.goal_y = '0;
    item.goal_vel_x  = '0; item.goal_vel_y = '0;
    for (int k = 0; k < 20; k++) begin
      it = '0;
      it.op = op_t'(k % 4);
      case (k / 4)
        0: begin
          it.top = 23'd512; it.gx = 24'sd2560; it.gy = -24'sd1280;
          it.gvx = 24'sd256; it.gvy = -24'sd512;
        end
        1: begin
          it.px = 24'sh7FFFFF; it.py = 24'sh800000; it.gx = 24'sh800000;
          it.gy = 24'sh7FFFFF; it.top = 23'h7FFFFF; it.vx = 24'sh800000;
          it.vy = 24'sh7FFFFF; it.gvx = 24'sh7FFFFF; it.gvy = 24'sh800000;
        end
        2: begin
          it.px = 24'sd100; it.py = -24'sd300; it.gx = 24'sd100; it.gy = -24'sd300;
          it.vx = 24'sd77; it.vy = -24'sd5; it.top = 23'd1000;
        end
        3: begin
          it.gx = 24'sd5000; it.gy = 24'sd3; it.top = 23'd0; it.vx = 24'sd9;
          it.gvx = -24'sd700; it.gvy = 24'sd700;
        end
        default: begin
          it.gx = 24'sd1; it.top = 23'd100; it.gvx = 24'sh800000; it.gvy = 24'sh7FFFFF;
        end
      endcase
      agents.push_back(it);
    end
    for (int k = 0; k < 1750; k++) agents.push_back(random_agent());
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (agents.size() != 0 || forces_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && forces_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_item_if.sv
hw/rtl/ssp_isqrt.sv
hw/rtl/ssp_divider.sv
hw/rtl/steering_seek_pursue_force_top.sv
verif/tb.sv
